// ===== sv/frpd_pkg.sv =====
`default_nettype none
package frpd_pkg;

  localparam int COORD_W   = 32;
  localparam int CNT_BITS  = 20;
  localparam int CNT_W     = CNT_BITS + 1;
  localparam int REG_W     = 21;
  localparam int NUM_LANES = 3;

  localparam int OUT_COUNT_RST = 10000;

  // config register indexes
  localparam logic [1:0] REG_IN_COUNT  = 2'd0;
  localparam logic [1:0] REG_OUT_COUNT = 2'd1;

  // open-bin sum: weight total <= 2^CNT_BITS, times one signed coordinate
  localparam int SUM_W  = COORD_W + CNT_W;
  // 2*sum + n, and its magnitude
  localparam int NUM_W  = SUM_W + 2;
  localparam int MAG_W  = SUM_W + 1;
  // divisor 2*n
  localparam int DEN_W  = CNT_W + 1;
  localparam int REM_W  = DEN_W + 1;
  localparam int STEP_W = $clog2(MAG_W);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  typedef struct packed {
    logic load_pos;
    logic mul_en;
    cnt_t weight;
    logic acc_add;
    logic acc_set;
    logic acc_clr;
    logic div_start;
  } lane_ctl_t;

  typedef struct packed {
    coord_t pos;
    coord_t avg;
    logic   done;
  } lane_res_t;

endpackage
`default_nettype wire

// ===== sv/fractional_ratio_point_downsampler_top.sv =====
`default_nettype none
// Fractional-ratio point downsampler.
// Input channel (in_valid/in_ready): one Q16.16 point per request. A frame of
// in_count points is reduced to out_count points by box averaging; when
// in_count <= out_count each point passes straight through.
// Output channel (out_valid/out_ready): one averaged point per completed bin,
// out_last_of_frame set on the final point of a frame.
// Config port (cfg_we/cfg_index/cfg_wdata): index 0 in_count, 1 out_count;
// a write to either register restarts the frame. Write only while idle.
// Timing: one request in flight at a time. Pass-through: accept, then emit.
// A point that does not complete a bin: multiply, accumulate, then idle. A
// point that completes a bin then waits on the 54-step restoring divider in
// each of the three coordinate lanes (the lanes divide in parallel).
// The output register holds a finished point while the receiver stalls; the
// next request is still accepted, and the block waits only when a second
// result is ready before the first is taken.
// Reset (synchronous, active low) clears sums and counters and loads
// in_count = 1, out_count = 10000.
module fractional_ratio_point_downsampler_top (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  frpd_pkg::coord_t             in_pos_x,
  input  frpd_pkg::coord_t             in_pos_y,
  input  frpd_pkg::coord_t             in_pos_z,
  output logic                         out_valid,
  input  wire                          out_ready,
  output frpd_pkg::coord_t             out_avg_x,
  output frpd_pkg::coord_t             out_avg_y,
  output frpd_pkg::coord_t             out_avg_z,
  output logic                         out_last_of_frame,
  input  wire                          cfg_we,
  input  wire [1:0]                    cfg_index,
  input  wire [frpd_pkg::REG_W-1:0]    cfg_wdata
);
  import frpd_pkg::*;

  localparam cnt_t       CNT_MAX       = {1'b1, {CNT_BITS{1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_MUL1, S_ACC1, S_MUL2, S_ACC2, S_DIV, S_EMIT
  } state_t;

  function automatic cnt_t eff_count(input logic [REG_W-1:0] v);
    cnt_t res;
    if (v == '0) begin
      res = CNT_W'(1);
    end else if (32'(v) > 32'(CNT_MAX)) begin
      res = CNT_MAX;
    end else begin
      res = CNT_W'(v);
    end
    return res;
  endfunction

  state_t              state_r;
  logic [REG_W-1:0]    in_count_r, out_count_r;
  cnt_t                bin_fill_r, inputs_seen_r;
  cnt_t                w_r, rest_r;
  logic                complete_r, last_r, pass_r;

  cnt_t                n_eff, m_eff, space, rest, w;
  logic                complete, last, pass, accept, cfg_hit;
  logic [CNT_W:0]      seen_inc;
  cnt_t                bin_fill_nxt, inputs_seen_nxt;

  lane_ctl_t                   ctl;
  lane_res_t [NUM_LANES-1:0]   lane_res;
  coord_t    [NUM_LANES-1:0]   pos_in;
  logic                        all_done, out_free, emit_load;

  assign n_eff    = eff_count(in_count_r);
  assign m_eff    = eff_count(out_count_r);
  assign seen_inc = {1'b0, inputs_seen_r} + 1'b1;
  assign last     = seen_inc >= {1'b0, n_eff};
  assign pass     = n_eff <= m_eff;
  assign space    = n_eff - bin_fill_r;
  assign complete = m_eff >= space;
  assign rest     = m_eff - space;
  assign w        = complete ? space : m_eff;

  assign bin_fill_nxt    = (last || pass) ? '0 : (complete ? rest : bin_fill_r + m_eff);
  assign inputs_seen_nxt = last ? '0 : seen_inc[CNT_W-1:0];

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign cfg_hit   = cfg_we && (cfg_index == REG_IN_COUNT || cfg_index == REG_OUT_COUNT);
  assign emit_load = (state_r == S_EMIT) && out_free;

  always_comb begin
    ctl.load_pos  = accept;
    ctl.mul_en    = (state_r == S_MUL1) || (state_r == S_MUL2);
    ctl.weight    = (state_r == S_MUL2) ? rest_r : w_r;
    ctl.acc_add   = (state_r == S_ACC1);
    ctl.acc_set   = (state_r == S_ACC2) && !last_r;
    ctl.acc_clr   = ((state_r == S_ACC2) && last_r) || cfg_hit;
    ctl.div_start = (state_r == S_MUL2);
  end

  assign pos_in[0] = in_pos_x;
  assign pos_in[1] = in_pos_y;
  assign pos_in[2] = in_pos_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      in_count_r    <= REG_W'(1);
      out_count_r   <= REG_W'(OUT_COUNT_RST);
      bin_fill_r    <= '0;
      inputs_seen_r <= '0;
      complete_r    <= 1'b0;
      last_r        <= 1'b0;
      pass_r        <= 1'b0;
    end else begin
      if (cfg_hit) begin
        if (cfg_index == REG_IN_COUNT) begin
          in_count_r <= cfg_wdata;
        end else begin
          out_count_r <= cfg_wdata;
        end
        bin_fill_r    <= '0;
        inputs_seen_r <= '0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            w_r           <= w;
            rest_r        <= rest;
            complete_r    <= complete;
            last_r        <= last;
            pass_r        <= pass;
            bin_fill_r    <= bin_fill_nxt;
            inputs_seen_r <= inputs_seen_nxt;
            state_r       <= pass ? S_EMIT : S_MUL1;
          end
        end
        S_MUL1: state_r <= S_ACC1;
        S_ACC1: state_r <= complete_r ? S_MUL2 : S_IDLE;
        S_MUL2: state_r <= S_ACC2;
        S_ACC2: state_r <= S_DIV;
        S_DIV: begin
          if (all_done) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    frpd_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .pos_in (pos_in[g]),
      .n_eff  (n_eff),
      .res    (lane_res[g])
    );
  end

  frpd_merge u_merge (
    .clk               (clk),
    .rst_n             (rst_n),
    .lane_res          (lane_res),
    .load              (emit_load),
    .sel_pass          (pass_r),
    .last              (last_r),
    .all_done          (all_done),
    .out_free          (out_free),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_avg_x         (out_avg_x),
    .out_avg_y         (out_avg_y),
    .out_avg_z         (out_avg_z),
    .out_last_of_frame (out_last_of_frame)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bin_fill_r < n_eff)
    else $error("open bin overfilled");

  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inputs_seen_r < n_eff)
    else $error("frame counter past frame end");

  a_div_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (complete_r && !pass_r))
    else $error("divide without a completed bin");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state_r) == S_EMIT))
    else $error("result shown outside emit");

endmodule
`default_nettype wire

// ===== sv/frpd_div.sv =====
`default_nettype none
module frpd_div (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  input  frpd_pkg::sum_t        num,
  input  frpd_pkg::cnt_t        den,
  output frpd_pkg::coord_t      quo,
  output logic                  done
);
  import frpd_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} dstate_t;

  dstate_t                  state_r;
  logic [MAG_W-1:0]         quo_r;
  logic [REM_W-1:0]         rem_r;
  logic [DEN_W-1:0]         den_r;
  logic                     neg_r;
  logic [STEP_W-1:0]        step_r;
  logic                     done_r;
  coord_t                   res_r;

  logic signed [NUM_W-1:0]  t;
  logic [NUM_W-1:0]         t_abs;
  logic [REM_W-1:0]         rem_sh;
  logic                     ge;
  logic [COORD_W-1:0]       q_lo;

  // round to nearest, ties up: floor((2s + n) / 2n)
  assign t      = (NUM_W'(num) <<< 1) + $signed(NUM_W'(den));
  assign t_abs  = t[NUM_W-1] ? NUM_W'(-t) : NUM_W'(t);
  assign rem_sh = {rem_r[REM_W-2:0], quo_r[MAG_W-1]};
  assign ge     = rem_sh >= REM_W'(den_r);
  assign q_lo   = quo_r[COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      case (state_r)
        D_IDLE: begin
          if (start) begin
            quo_r   <= t_abs[MAG_W-1:0];
            rem_r   <= '0;
            den_r   <= {den, 1'b0};
            neg_r   <= t[NUM_W-1];
            step_r  <= '0;
            done_r  <= 1'b0;
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          rem_r  <= ge ? (rem_sh - REM_W'(den_r)) : rem_sh;
          quo_r  <= {quo_r[MAG_W-2:0], ge};
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(MAG_W - 1)) begin
            state_r <= D_FIX;
          end
        end
        D_FIX: begin
          // floor of a negative value: -q, or -q-1 with a remainder
          if (neg_r) begin
            res_r <= (rem_r != '0) ? coord_t'(~q_lo) : coord_t'(~q_lo + 1'b1);
          end else begin
            res_r <= coord_t'(q_lo);
          end
          done_r  <= 1'b1;
          state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign quo  = res_r;
  assign done = done_r;

endmodule
`default_nettype wire

// ===== sv/frpd_lane.sv =====
`default_nettype none
module frpd_lane (
  input  wire                   clk,
  input  wire                   rst_n,
  input  frpd_pkg::lane_ctl_t   ctl,
  input  frpd_pkg::coord_t      pos_in,
  input  frpd_pkg::cnt_t        n_eff,
  output frpd_pkg::lane_res_t   res
);
  import frpd_pkg::*;

  coord_t                          pos_r;
  sum_t                            prod_r;
  sum_t                            sum_r;
  logic signed [COORD_W+CNT_W:0]   prod_full;
  coord_t                          avg;
  logic                            div_done;

  assign prod_full = $signed({1'b0, ctl.weight}) * pos_r;

  always_ff @(posedge clk) begin
    if (ctl.load_pos) begin
      pos_r <= pos_in;
    end
    if (ctl.mul_en) begin
      prod_r <= prod_full[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl.acc_clr) begin
      sum_r <= '0;
    end else if (ctl.acc_set) begin
      sum_r <= prod_r;
    end else if (ctl.acc_add) begin
      sum_r <= sum_r + prod_r;
    end
  end

  frpd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .num   (sum_r),
    .den   (n_eff),
    .quo   (avg),
    .done  (div_done)
  );

  assign res.pos  = pos_r;
  assign res.avg  = avg;
  assign res.done = div_done;

endmodule
`default_nettype wire

// ===== sv/frpd_merge.sv =====
`default_nettype none
module frpd_merge (
  input  wire                                         clk,
  input  wire                                         rst_n,
  input  frpd_pkg::lane_res_t [frpd_pkg::NUM_LANES-1:0] lane_res,
  input  wire                                         load,
  input  wire                                         sel_pass,
  input  wire                                         last,
  output logic                                        all_done,
  output logic                                        out_free,
  output logic                                        out_valid,
  input  wire                                         out_ready,
  output frpd_pkg::coord_t                            out_avg_x,
  output frpd_pkg::coord_t                            out_avg_y,
  output frpd_pkg::coord_t                            out_avg_z,
  output logic                                        out_last_of_frame
);
  import frpd_pkg::*;

  logic [NUM_LANES-1:0] done_vec;
  logic                 out_valid_r;
  coord_t               x_r, y_r, z_r;
  logic                 last_r;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      done_vec[i] = lane_res[i].done;
    end
  end

  assign all_done = &done_vec;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r    <= sel_pass ? lane_res[0].pos : lane_res[0].avg;
      y_r    <= sel_pass ? lane_res[1].pos : lane_res[1].avg;
      z_r    <= sel_pass ? lane_res[2].pos : lane_res[2].avg;
      last_r <= last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_avg_x         = x_r;
  assign out_avg_y         = y_r;
  assign out_avg_z         = z_r;
  assign out_last_of_frame = last_r;

  a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(done_vec) == 0 || $countones(done_vec) == NUM_LANES)
    else $error("lane dividers out of step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

endmodule
`default_nettype wire
